// ===== src/stereo_hop_peak_meter_assert.svh =====
// assertion macros for the stereo hop peak meter
// used by sthpm_merge and the top level under src; needs no other file
`ifndef STEREO_HOP_PEAK_METER_ASSERT_SVH
`define STEREO_HOP_PEAK_METER_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define STHPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define STHPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sthpm_pkg.sv =====
// shared constants, types and helper functions of the stereo hop peak meter
// no dependencies; every other file but the assertion header imports it
`default_nettype none

package sthpm_pkg;

    // sample and counter sizes
    localparam int SAMPLE_BITS    = 24;
    localparam int HOP_COUNT_BITS = 16;
    localparam int HOP_LEN_BITS   = 16;
    localparam int DB_BITS        = 17;

    // configuration port
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOP_LENGTH = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_MONO_MODE  = CFG_IDX_BITS'(1);
    localparam logic [HOP_LEN_BITS-1:0] HOP_LENGTH_RESET = HOP_LEN_BITS'(512);

    // level conversion
    localparam int LOG_FRAC_BITS = 24;
    localparam int MANT_BITS     = 32;
    localparam int SH_BITS       = $clog2(MANT_BITS);
    localparam int E_BITS        = $clog2(SAMPLE_BITS);
    localparam int LG_W          = E_BITS + LOG_FRAC_BITS + 1;
    localparam int SCALE_BITS    = 31;
    localparam int PROD_W        = LG_W - 1 + SCALE_BITS;
    localparam int DB_SHIFT      = 44;
    localparam longint FULL_SCALE_VAL = longint'(1) << (SAMPLE_BITS - 2);
    localparam longint SILENT_VAL     = FULL_SCALE_VAL / 10000000;
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = SAMPLE_BITS'(FULL_SCALE_VAL);
    localparam logic [SAMPLE_BITS-1:0] SILENT_MAX = SAMPLE_BITS'(SILENT_VAL);
    localparam logic [SCALE_BITS-1:0]  DB_SCALE   = SCALE_BITS'(1616142483);
    localparam logic signed [DB_BITS-1:0] DB_SILENT = -DB_BITS'(25600);

    // result queue
    localparam int OUT_DEPTH = 32;
    localparam int PTR_BITS  = $clog2(OUT_DEPTH);
    localparam int CNT_BITS  = $clog2(OUT_DEPTH + 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SAMPLE_BITS-1:0]        mag_t;
    typedef logic signed [DB_BITS-1:0]     db_t;

    // per-item control from the hop counter to both lanes
    typedef struct packed {
        logic take;
        logic hop_end;
    } lane_ctrl_t;

    // per-lane result into the merge stage
    typedef struct packed {
        logic valid;
        db_t  db;
        logic clip;
    } lane_res_t;

    // one queued result item
    typedef struct packed {
        db_t  left_db;
        db_t  right_db;
        logic left_clip;
        logic right_clip;
    } out_item_t;

    // position of the leading one, zero for zero
    function automatic logic [E_BITS-1:0] lead_one(input mag_t m);
        logic [E_BITS-1:0] e;
        e = '0;
        for (int i = 0; i < SAMPLE_BITS; i++) begin
            if (m[i])
            begin
                e = E_BITS'(i);
            end
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== src/sthpm_ifs.sv =====
// channel interfaces of the stereo hop peak meter: samples, results, configuration
// depends on sthpm_pkg
`default_nettype none

interface sthpm_in_if;
    import sthpm_pkg::*;
    logic    valid;
    logic    ready;
    sample_t left_sample;
    sample_t right_sample;
    modport source (output valid, left_sample, right_sample, input ready);
    modport sink (input valid, left_sample, right_sample, output ready);
endinterface

interface sthpm_out_if;
    import sthpm_pkg::*;
    logic valid;
    logic ready;
    db_t  left_peak_db;
    db_t  right_peak_db;
    logic left_clip;
    logic right_clip;
    modport source (output valid, left_peak_db, right_peak_db, left_clip, right_clip,
                    input ready);
    modport sink (input valid, left_peak_db, right_peak_db, left_clip, right_clip,
                  output ready);
endinterface

interface sthpm_cfg_if;
    import sthpm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [HOP_LEN_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/sthpm_db.sv =====
// peak to dB converter: normalize, 24 squaring stages for log2, scale and round
// depends on sthpm_pkg
`default_nettype none

module sthpm_db (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              peak_valid,
    input  wire sthpm_pkg::mag_t   peak,
    output sthpm_pkg::lane_res_t   res
);
    import sthpm_pkg::*;

    typedef struct packed {
        logic              silent;
        logic              clip;
        logic [E_BITS-1:0] e;
    } side_t;

    localparam logic signed [LG_W-1:0] LG_BIAS =
        LG_W'(SAMPLE_BITS - 2) << LOG_FRAC_BITS;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (DB_SHIFT - 1);

    // stage 0 holds the normalized mantissa, stage k the k-th squaring
    logic                     v_reg    [0:LOG_FRAC_BITS];
    logic [MANT_BITS-1:0]     x_reg    [0:LOG_FRAC_BITS];
    logic [LOG_FRAC_BITS-1:0] frac_reg [0:LOG_FRAC_BITS];
    side_t                    side_reg [0:LOG_FRAC_BITS];

    // normalize: leading one to the top of the mantissa
    logic [E_BITS-1:0]  e0;
    logic [SH_BITS-1:0] sh0;
    assign e0  = lead_one(peak);
    assign sh0 = SH_BITS'(MANT_BITS - 1) - SH_BITS'(e0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= peak_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]           <= MANT_BITS'(peak) << sh0;
        frac_reg[0]        <= '0;
        side_reg[0].silent <= (peak <= SILENT_MAX);
        side_reg[0].clip   <= (peak >= FULL_SCALE);
        side_reg[0].e      <= e0;
    end

    // squaring stages, one fraction bit each
    for (genvar k = 1; k <= LOG_FRAC_BITS; k++)
    begin : g_sq
        logic [2*MANT_BITS-1:0] sq;
        logic [MANT_BITS:0]     t;
        assign sq = x_reg[k-1] * x_reg[k-1];
        assign t  = sq[2*MANT_BITS-1:MANT_BITS-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[k]    <= t[MANT_BITS] ? t[MANT_BITS:1] : t[MANT_BITS-1:0];
            frac_reg[k] <= {frac_reg[k-1][LOG_FRAC_BITS-2:0], t[MANT_BITS]};
            side_reg[k] <= side_reg[k-1];
        end
    end

    // signed log2 relative to full scale, split into sign and magnitude
    logic signed [LG_W-1:0] lg;
    logic                   lg_neg;
    logic [LG_W-2:0]        lg_mag;
    assign lg     = $signed({1'b0, side_reg[LOG_FRAC_BITS].e, frac_reg[LOG_FRAC_BITS]})
                    - LG_BIAS;
    assign lg_neg = lg[LG_W-1];
    assign lg_mag = lg_neg ? (LG_W-1)'(-lg) : (LG_W-1)'(lg);

    logic            l_v_reg;
    logic            l_neg_reg;
    logic [LG_W-2:0] l_mag_reg;
    side_t           l_side_reg;

    logic              m_v_reg;
    logic              m_neg_reg;
    logic [PROD_W-1:0] m_prod_reg;
    side_t             m_side_reg;

    logic r_v_reg;
    db_t  r_db_reg;
    logic r_clip_reg;

    // scale by 20*log10(2), then round half away from zero
    logic [PROD_W-1:0]  rnd;
    logic [DB_BITS-1:0] q;
    assign rnd = m_prod_reg + ROUND_HALF;
    assign q   = DB_BITS'(rnd >> DB_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            r_v_reg <= 1'b0;
        end
        else
        begin
            l_v_reg <= v_reg[LOG_FRAC_BITS];
            m_v_reg <= l_v_reg;
            r_v_reg <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        l_neg_reg  <= lg_neg;
        l_mag_reg  <= lg_mag;
        l_side_reg <= side_reg[LOG_FRAC_BITS];
        m_neg_reg  <= l_neg_reg;
        m_prod_reg <= PROD_W'(l_mag_reg) * PROD_W'(DB_SCALE);
        m_side_reg <= l_side_reg;
        r_clip_reg <= m_side_reg.clip;
        if (m_side_reg.silent)
        begin
            r_db_reg <= DB_SILENT;
        end
        else
        begin
            r_db_reg <= m_neg_reg ? $signed(-q) : $signed(q);
        end
    end

    assign res.valid = r_v_reg;
    assign res.db    = r_db_reg;
    assign res.clip  = r_clip_reg;

endmodule

`default_nettype wire

// ===== src/sthpm_lane.sv =====
// one channel lane: sample magnitude, hop running maximum, dB conversion
// depends on sthpm_pkg and sthpm_db
`default_nettype none

module sthpm_lane (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sthpm_pkg::lane_ctrl_t ctrl,
    input  wire sthpm_pkg::sample_t  sample,
    output sthpm_pkg::lane_res_t     res
);
    import sthpm_pkg::*;

    mag_t max_reg;
    mag_t max_next;
    mag_t peak_reg;
    logic peak_v_reg;

    // magnitude; the most negative code maps to its exact magnitude
    mag_t mag;
    mag_t upd;
    assign mag = sample[SAMPLE_BITS-1] ? mag_t'(-sample) : mag_t'(sample);
    assign upd = (mag > max_reg) ? mag : max_reg;

    // running max, cleared when the hop closes
    always_comb
    begin
        max_next = max_reg;
        if (ctrl.take)
        begin
            max_next = ctrl.hop_end ? '0 : upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg    <= '0;
            peak_v_reg <= 1'b0;
        end
        else
        begin
            max_reg    <= max_next;
            peak_v_reg <= ctrl.take && ctrl.hop_end;
        end
    end

    // hop peak handed to the converter
    always_ff @(posedge clk)
    begin
        if (ctrl.take && ctrl.hop_end)
        begin
            peak_reg <= upd;
        end
    end

    sthpm_db u_db (
        .clk        (clk),
        .rst_n      (rst_n),
        .peak_valid (peak_v_reg),
        .peak       (peak_reg),
        .res        (res)
    );

endmodule

`default_nettype wire

// ===== src/sthpm_merge.sv =====
// merge stage: pairs the two lane results into one item and queues it for output
// depends on sthpm_pkg, sthpm_ifs and the assertion header
`default_nettype none
`include "stereo_hop_peak_meter_assert.svh"

module sthpm_merge (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sthpm_pkg::lane_res_t left_res,
    input  wire sthpm_pkg::lane_res_t right_res,
    sthpm_out_if.source               results
);
    import sthpm_pkg::*;

    out_item_t           mem [OUT_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    logic push;
    logic pop;
    assign push = left_res.valid;
    assign pop  = results.valid && results.ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    // queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{left_db: left_res.db, right_db: right_res.db,
                                 left_clip: left_res.clip, right_clip: right_res.clip};
        end
    end

    // head of the queue drives the result channel
    out_item_t head;
    assign head                  = mem[rd_ptr_reg];
    assign results.valid         = (count_reg != '0);
    assign results.left_peak_db  = head.left_db;
    assign results.right_peak_db = head.right_db;
    assign results.left_clip     = head.left_clip;
    assign results.right_clip    = head.right_clip;

    `STHPM_ASSERT_NOW(a_lanes_aligned, clk, rst_n, 1'b1, left_res.valid == right_res.valid, "lane results out of step")
    `STHPM_ASSERT_NOW(a_no_overflow, clk, rst_n, push, (count_reg != CNT_BITS'(OUT_DEPTH)) || pop, "result queue overflow")
    `STHPM_ASSERT_NEXT(a_count_tracks, clk, rst_n, push && !pop, count_reg == $past(count_reg) + CNT_BITS'(1), "queue fill level lost a push")

endmodule

`default_nettype wire

// ===== src/stereo_hop_peak_meter.sv =====
// top level of the stereo hop peak meter: configuration, hop counter, credits, lanes
// depends on sthpm_pkg, sthpm_ifs, sthpm_lane, sthpm_merge and the assertion header
`default_nettype none
`include "stereo_hop_peak_meter_assert.svh"

// Takes one stereo pair per clock and measures the absolute peak of each channel
// over hops of hop_length samples (0 counts as 1); at the end of each hop one item
// with both peaks in dB (Q8.8, -100 dB for silence) and clip flags is produced,
// behind the lane peak register and the converter stages. The two channels run in
// identical lanes, each with a 24-stage squaring pipeline for the log2, so a hop
// may close on every cycle. Results wait in a 32-entry queue; the sample channel
// stalls only when a hop would close while 32 results are still outstanding.
// mono_mode routes the left sample into both lanes. Configuration writes are
// taken on every cycle, but are meant to happen only while the block is idle.
module stereo_hop_peak_meter (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sthpm_cfg_if.sink   cfg,
    sthpm_in_if.sink    samples,
    sthpm_out_if.source results
);
    import sthpm_pkg::*;

    localparam int LIM_W =
        (HOP_COUNT_BITS > HOP_LEN_BITS ? HOP_COUNT_BITS : HOP_LEN_BITS) + 1;
    localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(1) << HOP_COUNT_BITS;

    logic [HOP_LEN_BITS-1:0]   hop_length_reg;
    logic                      mono_mode_reg;
    logic [HOP_COUNT_BITS-1:0] hop_position_reg;
    logic [CNT_BITS-1:0]       credit_reg;
    logic [CNT_BITS-1:0]       credit_next;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_length_reg <= HOP_LENGTH_RESET;
            mono_mode_reg  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_HOP_LENGTH: hop_length_reg <= cfg.data;
                CFG_MONO_MODE:  mono_mode_reg  <= cfg.data[0];
                default:        ;
            endcase
        end
    end

    // hop limit and end-of-hop detection, from registers only
    logic [LIM_W-1:0] len_ext;
    logic [LIM_W-1:0] limit;
    logic [LIM_W-1:0] count;
    logic             hop_end;
    assign len_ext = LIM_W'(hop_length_reg);
    assign count   = LIM_W'(hop_position_reg) + LIM_W'(1);
    assign hop_end = (count >= limit);

    always_comb
    begin
        priority if (len_ext == '0)
        begin
            limit = LIM_W'(1);
        end
        else if (len_ext > LIM_MAX)
        begin
            limit = LIM_MAX;
        end
        else
        begin
            limit = len_ext;
        end
    end

    // sample transfer; a closing sample needs a free result credit
    logic take;
    assign samples.ready = !hop_end || (credit_reg != CNT_BITS'(OUT_DEPTH));
    assign take          = samples.valid && samples.ready;

    logic out_xfer;
    logic issue;
    assign out_xfer = results.valid && results.ready;
    assign issue    = take && hop_end;

    always_comb
    begin
        credit_next = credit_reg;
        if (issue && !out_xfer)
        begin
            credit_next = credit_reg + CNT_BITS'(1);
        end
        else if (out_xfer && !issue)
        begin
            credit_next = credit_reg - CNT_BITS'(1);
        end
    end

    // hop position and outstanding result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_position_reg <= '0;
            credit_reg       <= '0;
        end
        else
        begin
            if (take)
            begin
                hop_position_reg <= hop_end ? '0 : count[HOP_COUNT_BITS-1:0];
            end
            credit_reg <= credit_next;
        end
    end

    // two channel lanes
    lane_ctrl_t ctrl;
    sample_t    right_in;
    lane_res_t  left_res;
    lane_res_t  right_res;
    assign ctrl.take    = take;
    assign ctrl.hop_end = hop_end;
    assign right_in     = mono_mode_reg ? samples.left_sample : samples.right_sample;

    sthpm_lane u_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (samples.left_sample),
        .res    (left_res)
    );

    sthpm_lane u_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (right_in),
        .res    (right_res)
    );

    sthpm_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .left_res  (left_res),
        .right_res (right_res),
        .results   (results)
    );

    `STHPM_ASSERT_NOW(a_credit_bound, clk, rst_n, 1'b1, credit_reg <= CNT_BITS'(OUT_DEPTH), "result credits exceed queue depth")
    `STHPM_ASSERT_NEXT(a_hop_restart, clk, rst_n, issue, hop_position_reg == '0, "hop position not cleared at hop end")
    `STHPM_ASSERT_NOW(a_stall_when_full, clk, rst_n, !samples.ready, credit_reg == CNT_BITS'(OUT_DEPTH), "input stalled with free credits")

endmodule

`default_nettype wire

// ===== tb/stereo_hop_peak_meter_test.sv =====
// self-checking testbench of the stereo hop peak meter: directed table, then random phases
// checks every hop result against a typed table level or an in-bench level predictor
// depends on sthpm_pkg, sthpm_ifs and the stereo_hop_peak_meter rtl
`timescale 1ns / 1ps

module stereo_hop_peak_meter_test;
    import sthpm_pkg::*;

    localparam int HALF_NS      = 6;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 250;
    localparam int SHOWN_MAX    = 10;

    // register indexes past the end of the map, writes there are dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = CFG_IDX_BITS'(3);

    // sample corners
    localparam sample_t S_FULL = sample_t'(FULL_SCALE);
    localparam sample_t S_MAX  = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam sample_t S_MIN  = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // levels that follow directly from the conversion rule
    localparam db_t LVL_FULL = db_t'(0);
    localparam db_t LVL_TOP  = db_t'(1541);
    localparam db_t LVL_LSB  = -db_t'(33908);

    typedef enum logic {ROW_CFG, ROW_PAIR} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_IDX_BITS-1:0] idx;
        logic [HOP_LEN_BITS-1:0] data;
        sample_t                 l;
        sample_t                 r;
        bit                      known;
        out_item_t               want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    sthpm_cfg_if regs_ch();
    sthpm_in_if  pairs_ch();
    sthpm_out_if levels_ch();

    stereo_hop_peak_meter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (regs_ch),
        .samples (pairs_ch),
        .results (levels_ch)
    );

    // predictor state
    logic [HOP_LEN_BITS-1:0]   hop_len_r = HOP_LENGTH_RESET;
    logic                      mono_r    = 1'b0;
    logic [HOP_COUNT_BITS-1:0] hop_count = '0;
    mag_t                      left_hold = '0;
    mag_t                      right_hold = '0;

    out_item_t levels_due[$];
    plan_row_t plan[$];

    int  errors       = 0;
    int  pairs_sent   = 0;
    int  levels_seen  = 0;
    int  writes_done  = 0;
    bit  steady       = 1'b0;
    bit  want_hold    = 1'b0;
    bit  hold_done    = 1'b0;
    int  hold_cycles  = 0;

    // clock
    initial clk = 1'b0;
    always #(HALF_NS) clk = ~clk;

    // watchdog
    initial
    begin
        #(LIMIT_CYCLES * 2 * HALF_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // absolute value of a sample, most negative kept exactly
    function automatic mag_t mag_of(input sample_t s);
        return s[SAMPLE_BITS-1] ? mag_t'(-s) : mag_t'(s);
    endfunction

    // peak magnitude to Q8.8 dB through a bitwise log2 by repeated squaring
    function automatic db_t level_q88(input mag_t m);
        logic [63:0] x;
        logic [63:0] frac;
        logic [63:0] mag;
        logic [63:0] q;
        longint      lg;
        int          e;
        if (64'(m) * 64'd10_000_000 <= 64'(FULL_SCALE))
        begin
            return DB_SILENT;
        end
        e = 0;
        for (int i = 0; i < SAMPLE_BITS; i++)
        begin
            if (m[i])
            begin
                e = i;
            end
        end
        x = (64'(m) << (31 - e)) & 64'hFFFF_FFFF;
        frac = '0;
        for (int i = 0; i < LOG_FRAC_BITS; i++)
        begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= 64'h1_0000_0000)
            begin
                frac = frac | 64'd1;
                x = x >> 1;
            end
        end
        lg = longint'((64'(e) << LOG_FRAC_BITS) | frac)
             - (longint'(SAMPLE_BITS - 2) << LOG_FRAC_BITS);
        mag = (lg < 0) ? 64'(-lg) : 64'(lg);
        q = (mag * 64'(DB_SCALE) + (64'd1 << (DB_SHIFT - 1))) >> DB_SHIFT;
        return (lg < 0) ? -db_t'(q) : db_t'(q);
    endfunction

    // one accepted pair through the hop tracker; hit when the hop closes
    task automatic meter_take(input sample_t l, input sample_t r,
                              output bit hit, output out_item_t lvl);
        mag_t                    ml;
        mag_t                    mr;
        logic [HOP_COUNT_BITS:0] lim;
        logic [HOP_COUNT_BITS:0] cnt;
        ml = mag_of(l);
        mr = mono_r ? ml : mag_of(r);
        lim = (hop_len_r == 0) ? (HOP_COUNT_BITS + 1)'(1) : (HOP_COUNT_BITS + 1)'(hop_len_r);
        if (ml > left_hold)
        begin
            left_hold = ml;
        end
        if (mr > right_hold)
        begin
            right_hold = mr;
        end
        cnt = (HOP_COUNT_BITS + 1)'(hop_count) + 1'b1;
        hit = 1'b0;
        lvl = '0;
        if (cnt < lim)
        begin
            hop_count = cnt[HOP_COUNT_BITS-1:0];
        end
        else
        begin
            hit = 1'b1;
            lvl.left_db    = level_q88(left_hold);
            lvl.right_db   = level_q88(right_hold);
            lvl.left_clip  = left_hold >= FULL_SCALE;
            lvl.right_clip = right_hold >= FULL_SCALE;
            hop_count  = '0;
            left_hold  = '0;
            right_hold = '0;
        end
    endtask

    // random sample: corners, small magnitudes of either sign, or any pattern
    function automatic sample_t rand_sample();
        int unsigned pick;
        int unsigned v;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            case ($urandom_range(0, 7))
                0: return '0;
                1: return S_FULL;
                2: return -S_FULL;
                3: return S_MIN;
                4: return S_MAX;
                5: return sample_t'(1);
                6: return sample_t'(-1);
                default: return S_FULL - 1'b1;
            endcase
        end
        if (pick < 45)
        begin
            v = $urandom >> $urandom_range(8, 31);
            return $urandom_range(0, 1) ? sample_t'(-v) : sample_t'(v);
        end
        return sample_t'($urandom);
    endfunction

    // offer one pair at the falling edge, with random gaps unless steady, until transfer
    task automatic push_pair(input sample_t l, input sample_t r,
                             input bit known, input out_item_t typed);
        bit        hit;
        out_item_t lvl;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 13)
        begin
            pairs_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pairs_ch.valid        <= 1'b1;
        pairs_ch.left_sample  <= l;
        pairs_ch.right_sample <= r;
        do @(posedge clk); while (!pairs_ch.ready);
        pairs_sent++;
        meter_take(l, r, hit, lvl);
        if (hit)
        begin
            levels_due.insert(levels_due.size(), known ? typed : lvl);
        end
    endtask

    // stop offering, wait for every outstanding level, then let the pipeline empty
    task automatic settle();
        @(negedge clk);
        pairs_ch.valid <= 1'b0;
        while (levels_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write transfer
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [HOP_LEN_BITS-1:0] val);
        @(negedge clk);
        regs_ch.valid <= 1'b1;
        regs_ch.index <= idx;
        regs_ch.data  <= val;
        do @(posedge clk); while (!regs_ch.ready);
        case (idx)
            CFG_HOP_LENGTH: hop_len_r = val;
            CFG_MONO_MODE:  mono_r = val[0];
            default: ;
        endcase
        writes_done++;
        @(negedge clk);
        regs_ch.valid <= 1'b0;
    endtask

    // random phase under one setting
    task automatic run_phase(input logic [HOP_LEN_BITS-1:0] hop, input bit mono,
                             input int count, input bit no_gaps, input bit squeeze);
        settle();
        write_reg(CFG_HOP_LENGTH, hop);
        write_reg(CFG_MONO_MODE, {15'($urandom), mono});
        steady = no_gaps;
        if (squeeze)
        begin
            want_hold = 1'b1;
        end
        for (int k = 0; k < count; k++)
        begin
            if (k == count / 2)
            begin
                settle();
            end
            push_pair(rand_sample(), rand_sample(), 1'b0, '0);
        end
        steady = 1'b0;
    endtask

    // table row builders
    function automatic plan_row_t cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                          input logic [HOP_LEN_BITS-1:0] val);
        plan_row_t p;
        p = '{kind: ROW_CFG, idx: idx, data: val, l: '0, r: '0, known: 1'b0, want: '0};
        return p;
    endfunction

    function automatic plan_row_t pair_row(input sample_t l, input sample_t r);
        plan_row_t p;
        p = '{kind: ROW_PAIR, idx: '0, data: '0, l: l, r: r, known: 1'b0, want: '0};
        return p;
    endfunction

    function automatic plan_row_t known_row(input sample_t l, input sample_t r,
                                            input db_t ldb, input db_t rdb,
                                            input logic lc, input logic rc);
        plan_row_t p;
        p = pair_row(l, r);
        p.known = 1'b1;
        p.want  = '{left_db: ldb, right_db: rdb, left_clip: lc, right_clip: rc};
        return p;
    endfunction

    // append one row to the stimulus table
    task automatic add_row(input plan_row_t p);
        plan.insert(plan.size(), p);
    endtask

    // level sink ready: random gaps, one long hold-off on request
    always @(negedge clk)
    begin
        if (want_hold && !hold_done)
        begin
            levels_ch.ready <= 1'b0;
            hold_cycles++;
            if (hold_cycles >= HOLD_CYCLES)
            begin
                hold_done = 1'b1;
            end
        end
        else
        begin
            levels_ch.ready <= steady || ($urandom_range(0, 99) >= 13);
        end
    end

    // compare each level transfer with the oldest expectation
    always @(posedge clk)
    begin : check_levels
        out_item_t got;
        out_item_t want;
        if (rst_n && levels_ch.valid && levels_ch.ready)
        begin
            got.left_db    = levels_ch.left_peak_db;
            got.right_db   = levels_ch.right_peak_db;
            got.left_clip  = levels_ch.left_clip;
            got.right_clip = levels_ch.right_clip;
            levels_seen++;
            if (levels_due.size() == 0)
            begin
                errors++;
                if (errors <= SHOWN_MAX)
                begin
                    $display("%0t: level with none pending: L %0d R %0d clip %b%b", $realtime,
                             got.left_db, got.right_db, got.left_clip, got.right_clip);
                end
            end
            else
            begin
                want = levels_due.pop_front();
                if (got.left_db !== want.left_db || got.right_db !== want.right_db ||
                    got.left_clip !== want.left_clip || got.right_clip !== want.right_clip)
                begin
                    errors++;
                    if (errors <= SHOWN_MAX)
                    begin
                        $display("%0t: level mismatch: exp L %0d R %0d clip %b%b, got L %0d R %0d clip %b%b",
                                 $realtime, want.left_db, want.right_db, want.left_clip,
                                 want.right_clip, got.left_db, got.right_db, got.left_clip,
                                 got.right_clip);
                    end
                end
            end
        end
    end

    // reset, directed table, random phases, final drain
    initial
    begin
        rst_n = 1'b0;
        regs_ch.valid = 1'b0;
        regs_ch.index = '0;
        regs_ch.data  = '0;
        pairs_ch.valid        = 1'b0;
        pairs_ch.left_sample  = '0;
        pairs_ch.right_sample = '0;
        levels_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: corners under the reset hop, mid-hop changes, mono, zero hop, spare indexes
        add_row(pair_row('0, '0));
        add_row(pair_row(S_FULL, -S_FULL));
        add_row(cfg_row(CFG_HOP_LENGTH, 16'd1));
        add_row(known_row('0, '0, LVL_FULL, LVL_FULL, 1'b1, 1'b1));
        add_row(known_row('0, '0, DB_SILENT, DB_SILENT, 1'b0, 1'b0));
        add_row(known_row(S_MIN, sample_t'(1), LVL_TOP, LVL_LSB, 1'b1, 1'b0));
        add_row(pair_row(S_MAX, S_MIN));
        add_row(pair_row(S_FULL - 1'b1, -(S_FULL + 1'b1)));
        add_row(known_row(sample_t'(1), sample_t'(-1), LVL_LSB, LVL_LSB, 1'b0, 1'b0));
        add_row(cfg_row(CFG_MONO_MODE, 16'd1));
        add_row(known_row(S_MIN, '0, LVL_TOP, LVL_TOP, 1'b1, 1'b1));
        add_row(pair_row(sample_t'(5), S_MAX));
        add_row(cfg_row(CFG_HOP_LENGTH, 16'd0));
        add_row(known_row(S_FULL, '0, LVL_FULL, LVL_FULL, 1'b1, 1'b1));
        add_row(cfg_row(CFG_MONO_MODE, 16'd0));
        add_row(pair_row(sample_t'(123456), sample_t'(-654321)));
        add_row(cfg_row(CFG_HOP_LENGTH, 16'd3));
        add_row(pair_row(sample_t'(-3), sample_t'(70000)));
        add_row(pair_row(sample_t'(2000000), sample_t'(-9)));
        add_row(pair_row(sample_t'(-1048576), sample_t'(300)));
        add_row(cfg_row(CFG_SPARE_A, 16'hFFFF));
        add_row(cfg_row(CFG_SPARE_B, 16'h0001));
        add_row(pair_row(sample_t'(77), sample_t'(-5000000)));
        add_row(pair_row(sample_t'(-8000000), sample_t'(2)));
        add_row(pair_row(sample_t'(4), sample_t'(-4)));
        add_row(cfg_row(CFG_HOP_LENGTH, 16'd5));
        add_row(pair_row(sample_t'(-400), sample_t'(9000)));
        add_row(pair_row(sample_t'(6000000), sample_t'(-1)));
        add_row(cfg_row(CFG_HOP_LENGTH, 16'd2));
        add_row(pair_row(sample_t'(12), sample_t'(-12)));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                push_pair(plan[i].l, plan[i].r, plan[i].known, plan[i].want);
            end
        end

        // random phases; the first fills the result queue behind a long sink hold-off
        run_phase(16'd1, 1'b0, 300, 1'b0, 1'b1);
        run_phase(16'd2, 1'b1, 200, 1'b1, 1'b0);
        run_phase(HOP_LEN_BITS'($urandom_range(3, 40)), 1'b0, 400, 1'b0, 1'b0);
        run_phase(HOP_LEN_BITS'($urandom_range(3, 40)), 1'b1, 200, 1'b0, 1'b0);
        run_phase(HOP_LEN_BITS'($urandom_range(41, 600)), 1'b1, 400, 1'b0, 1'b0);
        run_phase(16'd0, 1'b0, 100, 1'b0, 1'b0);
        // longest hop, far from complete, stays silent
        run_phase(16'hFFFF, 1'b0, 20, 1'b0, 1'b0);
        // trailing partial hop must stay silent
        run_phase(16'd7, 1'b0, 10, 1'b0, 1'b0);

        settle();
        $display("covered %0d sample pairs, %0d hop levels, %0d register writes",
                 pairs_sent, levels_seen, writes_done);
        $display("hop lengths 0 to 65535, mono on and off, full result queue with input stall");
        if (errors == 0 && levels_due.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("%0d errors, %0d levels never seen", errors, levels_due.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
